/* hw/rtl/scalar_immediate_alu_defines.svh */
// Assertion macros shared by the scalar immediate ALU RTL.
`ifndef SCALAR_IMMEDIATE_ALU_DEFINES_SVH
`define SCALAR_IMMEDIATE_ALU_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define SIA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define SIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sia_pkg.sv */
// Types and operation codes of the scalar immediate ALU.
package sia_pkg;

    typedef struct packed {
        logic [4:0]  func;
        logic [31:0] dest_value;
        logic [15:0] imm16;
        logic [31:0] literal32;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result;
        logic        dest_write;
        logic        cond_out;
        logic        cond_write;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    localparam logic [4:0] OP_MOVK    = 5'd0;
    localparam logic [4:0] OP_CMOVK   = 5'd1;
    localparam logic [4:0] OP_CMP_SEQ = 5'd2;
    localparam logic [4:0] OP_CMP_SNE = 5'd3;
    localparam logic [4:0] OP_CMP_SGT = 5'd4;
    localparam logic [4:0] OP_CMP_SGE = 5'd5;
    localparam logic [4:0] OP_CMP_SLT = 5'd6;
    localparam logic [4:0] OP_CMP_SLE = 5'd7;
    localparam logic [4:0] OP_CMP_UEQ = 5'd8;
    localparam logic [4:0] OP_CMP_UNE = 5'd9;
    localparam logic [4:0] OP_CMP_UGT = 5'd10;
    localparam logic [4:0] OP_CMP_UGE = 5'd11;
    localparam logic [4:0] OP_CMP_ULT = 5'd12;
    localparam logic [4:0] OP_CMP_ULE = 5'd13;
    localparam logic [4:0] OP_ADDK    = 5'd14;
    localparam logic [4:0] OP_MULK    = 5'd15;
    localparam logic [4:0] OP_GETREG  = 5'd16;
    localparam logic [4:0] OP_SETREG  = 5'd17;
    localparam logic [4:0] OP_SETIMM  = 5'd18;

endpackage

/* hw/rtl/sia_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module sia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/scalar_immediate_alu.sv */
// Scalar ALU for instructions that carry a 16-bit immediate, with a hardware register file.
//
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one instruction per
// transaction: operation code, current destination value, raw immediate and a 32-bit
// literal. The output channel (o_out_valid, i_out_stall, o_out_data) returns exactly one
// transaction per instruction: the new destination value with its write flag and the
// condition bit with its update flag.
// An instruction is accepted and then executed. In the accept cycle the hardware
// register named by the immediate is read from the register-file RAM; in the execute
// cycle the result is formed, the register is written back for set operations and the
// output register is loaded. The read data of that RAM is registered, and an instruction
// completes its read-modify-write before the next one is accepted, so the block stalls its
// input while an instruction is in execute. The result is presented from the output
// register from the edge that ends the execute cycle.
// A finished result waits in the output register while the next instruction is accepted
// and read. If the receiver still stalls when that instruction is ready to execute, the
// block holds in the execute state and stalls its input until the output register frees.
// Reset (synchronous, active low) returns to idle, drops the output valid, clears the
// condition bit and clears one valid bit per register-file entry, so every hardware
// register reads as zero until it is first written. There is no clearing pass.
`include "scalar_immediate_alu_defines.svh"

module scalar_immediate_alu #(
    parameter int HWREG_COUNT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sia_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sia_pkg::t_out_item   o_out_data
);

    localparam int         AW        = $clog2(HWREG_COUNT);
    localparam logic [6:0] LP_HW_CNT = 7'(HWREG_COUNT);

    // Control state.
    sia_pkg::t_state       r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  r_cond, n_cond;
    logic [HWREG_COUNT-1:0] r_valid;

    // Payload registers.
    sia_pkg::t_in_item     r_item;
    sia_pkg::t_out_item    r_out, n_out;

    // Datapath signals.
    logic                  w_accept;
    logic                  w_exec_fire;
    logic                  w_in_id_ok;
    logic                  w_id_ok;
    logic [AW-1:0]         w_addr;
    logic [31:0]           w_ram_rdata;
    logic [31:0]           w_hw;
    logic [31:0]           w_simm;
    logic [31:0]           w_uimm;
    logic [31:0]           w_sum;
    logic                  w_ovf;
    logic [31:0]           w_mul;
    logic [4:0]            w_off;
    logic [31:0]           w_mask;
    logic [31:0]           w_set_data;
    logic [31:0]           w_wdata;
    logic                  w_is_set;
    logic                  w_ram_we;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != sia_pkg::S_IDLE);
    assign w_in_id_ok  = ({1'b0, i_in_data.imm16[5:0]} < LP_HW_CNT);

    // The state machine: idle takes an instruction, execute waits for the output slot.
    always_comb begin
        n_state     = r_state;
        w_exec_fire = 1'b0;
        unique case (r_state)
            sia_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sia_pkg::S_EXEC;
                end
            end
            sia_pkg::S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_exec_fire = 1'b1;
                    n_state     = sia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sia_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The instruction is held for the execute cycle; the RAM read runs in parallel.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    sia_ram #(
        .WIDTH (32),
        .DEPTH (HWREG_COUNT)
    ) u_hwreg_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_re    (w_accept && w_in_id_ok),
        .i_raddr (i_in_data.imm16[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Register file lookup. An id beyond the file, or an entry never written, reads zero.
    assign w_id_ok = ({1'b0, r_item.imm16[5:0]} < LP_HW_CNT);
    assign w_addr  = r_item.imm16[AW-1:0];
    assign w_hw    = (w_id_ok && r_valid[w_addr]) ? w_ram_rdata : 32'd0;

    // Operand forms of the immediate.
    assign w_simm = {{16{r_item.imm16[15]}}, r_item.imm16};
    assign w_uimm = {16'd0, r_item.imm16};

    // Add with signed overflow: same operand signs and a different sum sign.
    assign w_sum = r_item.dest_value + w_simm;
    assign w_ovf = (r_item.dest_value[31] == w_simm[31]) && (w_sum[31] != w_simm[31]);

    // Only the low word of the product is kept.
    assign w_mul = r_item.dest_value * w_simm;

    // Bit field: size-1 in [15:11], offset in [10:6]. The shifted all-ones base gives
    // exactly size ones, so a size of 32 needs no special case; bits past 31 drop off.
    assign w_off  = r_item.imm16[10:6];
    assign w_mask = (32'hFFFF_FFFF >> (5'd31 - r_item.imm16[15:11])) << w_off;

    assign w_set_data = (r_item.func == sia_pkg::OP_SETIMM) ? r_item.literal32
                                                            : r_item.dest_value;
    assign w_wdata    = (w_hw & ~w_mask) | ((w_set_data << w_off) & w_mask);
    assign w_is_set   = (r_item.func == sia_pkg::OP_SETREG) ||
                        (r_item.func == sia_pkg::OP_SETIMM);
    assign w_ram_we   = w_exec_fire && w_is_set && w_id_ok;

    // Result and condition bit of the instruction in execute.
    always_comb begin
        n_out            = '0;
        n_cond           = r_cond;
        case (r_item.func)
            sia_pkg::OP_MOVK: begin
                n_out.result     = w_simm;
                n_out.dest_write = 1'b1;
            end
            sia_pkg::OP_CMOVK: begin
                if (r_cond) begin
                    n_out.result     = w_simm;
                    n_out.dest_write = 1'b1;
                end
            end
            sia_pkg::OP_CMP_SEQ: n_cond = (r_item.dest_value == w_simm);
            sia_pkg::OP_CMP_SNE: n_cond = (r_item.dest_value != w_simm);
            sia_pkg::OP_CMP_SGT: n_cond = ($signed(r_item.dest_value) >  $signed(w_simm));
            sia_pkg::OP_CMP_SGE: n_cond = ($signed(r_item.dest_value) >= $signed(w_simm));
            sia_pkg::OP_CMP_SLT: n_cond = ($signed(r_item.dest_value) <  $signed(w_simm));
            sia_pkg::OP_CMP_SLE: n_cond = ($signed(r_item.dest_value) <= $signed(w_simm));
            sia_pkg::OP_CMP_UEQ: n_cond = (r_item.dest_value == w_uimm);
            sia_pkg::OP_CMP_UNE: n_cond = (r_item.dest_value != w_uimm);
            sia_pkg::OP_CMP_UGT: n_cond = (r_item.dest_value >  w_uimm);
            sia_pkg::OP_CMP_UGE: n_cond = (r_item.dest_value >= w_uimm);
            sia_pkg::OP_CMP_ULT: n_cond = (r_item.dest_value <  w_uimm);
            sia_pkg::OP_CMP_ULE: n_cond = (r_item.dest_value <= w_uimm);
            sia_pkg::OP_ADDK: begin
                n_out.result     = w_sum;
                n_out.dest_write = 1'b1;
                n_cond           = w_ovf;
            end
            sia_pkg::OP_MULK: begin
                n_out.result     = w_mul;
                n_out.dest_write = 1'b1;
            end
            sia_pkg::OP_GETREG: begin
                n_out.result     = (w_hw & w_mask) >> w_off;
                n_out.dest_write = 1'b1;
            end
            default: begin
                // Set operations and unused codes write neither destination nor condition.
            end
        endcase
        if (r_item.func >= sia_pkg::OP_CMP_SEQ && r_item.func <= sia_pkg::OP_ADDK) begin
            n_out.cond_write = 1'b1;
        end
        n_out.cond_out = n_cond;
    end

    // Output register and its valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec_fire) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cond      <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_exec_fire) begin
                r_cond <= n_cond;
            end
            if (w_ram_we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted transaction always moves into execute.
    `SIA_ASSERT_NEXT(a_accept_to_exec, w_accept, r_state == sia_pkg::S_EXEC, "accept did not start execute")
    // Every executed instruction presents a result in the next cycle.
    `SIA_ASSERT_NEXT(a_exec_to_out, w_exec_fire, o_out_valid, "executed instruction produced no output")
    // The condition bit moves only when an instruction executes.
    `SIA_ASSERT_NEXT(a_cond_hold, !w_exec_fire, r_cond == $past(r_cond), "condition bit changed while idle")
    // The register file is written only from execute by a set operation.
    `SIA_ASSERT_IMPL(a_ram_we_ok, w_ram_we, (r_state == sia_pkg::S_EXEC) && w_is_set, "stray RAM write")

endmodule

/* tb/tb_scalar_immediate_alu.sv */
// Self-checking testbench for the scalar immediate ALU with its hardware register file.
`timescale 1ns / 100ps

module tb_scalar_immediate_alu;

    localparam int HWREG_COUNT  = 64;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_PRINTS   = 40;

    // One pending instruction. When drain_first is set, the sender waits until every
    // expected result has come back before it offers this instruction.
    typedef struct {
        sia_pkg::t_in_item item;
        bit                drain_first;
    } t_pending;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    sia_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    sia_pkg::t_out_item out_data;

    scalar_immediate_alu #(
        .HWREG_COUNT(HWREG_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow of the block's architectural state, advanced once per accepted instruction.
    logic        cond_flag;
    logic [31:0] hwreg_file [HWREG_COUNT];

    t_pending           pending_q [$];
    sia_pkg::t_out_item expected_q [$];
    t_pending           cur_entry;

    int          total_items = 0;
    int          sent_cnt = 0;
    int          results_seen = 0;
    int          error_cnt = 0;
    int          cycle_cnt = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // Bit-field mask of the hardware register operations. A size of 32 covers the
    // whole word, and a field that runs past bit 31 is simply cut off there.
    function automatic logic [31:0] field_mask(logic [15:0] imm);
        logic [5:0]  size;
        logic [31:0] base;
        size = {1'b0, imm[15:11]} + 6'd1;
        base = (size == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << size) - 32'd1);
        return base << imm[10:6];
    endfunction

    // Computes the result of one instruction and updates the shadow state.
    function automatic sia_pkg::t_out_item execute_instr(sia_pkg::t_in_item it);
        sia_pkg::t_out_item res;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] sum;
        logic [31:0] mask;
        logic [31:0] data;
        logic [31:0] hw;
        logic [5:0]  id;
        logic [4:0]  off;
        res  = '0;
        simm = {{16{it.imm16[15]}}, it.imm16};
        zimm = {16'h0000, it.imm16};
        mask = field_mask(it.imm16);
        id   = it.imm16[5:0];
        off  = it.imm16[10:6];
        data = (it.func == sia_pkg::OP_SETIMM) ? it.literal32 : it.dest_value;
        case (it.func)
            sia_pkg::OP_MOVK: begin
                res.result = simm;
                res.dest_write = 1'b1;
            end
            sia_pkg::OP_CMOVK: begin
                if (cond_flag) begin
                    res.result = simm;
                    res.dest_write = 1'b1;
                end
            end
            sia_pkg::OP_CMP_SEQ: cond_flag = $signed(it.dest_value) == $signed(simm);
            sia_pkg::OP_CMP_SNE: cond_flag = $signed(it.dest_value) != $signed(simm);
            sia_pkg::OP_CMP_SGT: cond_flag = $signed(it.dest_value) >  $signed(simm);
            sia_pkg::OP_CMP_SGE: cond_flag = $signed(it.dest_value) >= $signed(simm);
            sia_pkg::OP_CMP_SLT: cond_flag = $signed(it.dest_value) <  $signed(simm);
            sia_pkg::OP_CMP_SLE: cond_flag = $signed(it.dest_value) <= $signed(simm);
            sia_pkg::OP_CMP_UEQ: cond_flag = it.dest_value == zimm;
            sia_pkg::OP_CMP_UNE: cond_flag = it.dest_value != zimm;
            sia_pkg::OP_CMP_UGT: cond_flag = it.dest_value >  zimm;
            sia_pkg::OP_CMP_UGE: cond_flag = it.dest_value >= zimm;
            sia_pkg::OP_CMP_ULT: cond_flag = it.dest_value <  zimm;
            sia_pkg::OP_CMP_ULE: cond_flag = it.dest_value <= zimm;
            sia_pkg::OP_ADDK: begin
                sum = it.dest_value + simm;
                res.result = sum;
                res.dest_write = 1'b1;
                // Signed overflow: equal operand signs and a sum of the other sign.
                cond_flag = (it.dest_value[31] == simm[31]) && (sum[31] != simm[31]);
            end
            sia_pkg::OP_MULK: begin
                res.result = it.dest_value * simm;
                res.dest_write = 1'b1;
            end
            sia_pkg::OP_GETREG: begin
                hw = (id < HWREG_COUNT) ? hwreg_file[id] : 32'd0;
                res.result = (hw & mask) >> off;
                res.dest_write = 1'b1;
            end
            sia_pkg::OP_SETREG, sia_pkg::OP_SETIMM: begin
                if (id < HWREG_COUNT) begin
                    hwreg_file[id] = (hwreg_file[id] & ~mask) | ((data << off) & mask);
                end
            end
            default: begin
            end
        endcase
        // Every compare and the add update the condition bit.
        if ((it.func >= sia_pkg::OP_CMP_SEQ && it.func <= sia_pkg::OP_CMP_ULE) ||
            it.func == sia_pkg::OP_ADDK) begin
            res.cond_write = 1'b1;
        end
        res.cond_out = cond_flag;
        return res;
    endfunction

    function automatic logic [15:0] hwreg_imm(logic [4:0] size_m1, logic [4:0] off,
                                              logic [5:0] id);
        return {size_m1, off, id};
    endfunction

    task automatic add_instr(logic [4:0] func, logic [31:0] dval, logic [15:0] imm,
                             logic [31:0] lit, bit drain);
        t_pending p;
        p.item.func       = func;
        p.item.dest_value = dval;
        p.item.imm16      = imm;
        p.item.literal32  = lit;
        p.drain_first     = drain;
        pending_q.push_back(p);
        total_items++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A data word that lands on the corner values fairly often.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_instr(bit drain);
        logic [4:0]  func;
        logic [31:0] dval;
        logic [15:0] imm;
        logic [5:0]  id;
        logic [4:0]  size_m1;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            func = 5'($urandom_range(19, 31));
        end else if (r < 40) begin
            func = 5'($urandom_range(sia_pkg::OP_GETREG, sia_pkg::OP_SETIMM));
        end else begin
            func = 5'($urandom_range(sia_pkg::OP_MOVK, sia_pkg::OP_MULK));
        end
        dval = pick_word();
        case ($urandom_range(0, 5))
            0: imm = 16'h8000;
            1: imm = 16'h7FFF;
            2: imm = 16'hFFFF;
            default: imm = 16'($urandom);
        endcase
        if (func >= sia_pkg::OP_GETREG && func <= sia_pkg::OP_SETIMM) begin
            // Keep most accesses on a few registers so sets and gets meet each other.
            id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 3));
            size_m1 = ($urandom_range(0, 4) == 0) ? 5'd31 : 5'($urandom);
            imm = hwreg_imm(size_m1, 5'($urandom), id);
        end else if (func >= sia_pkg::OP_CMP_SEQ && func <= sia_pkg::OP_CMP_ULE &&
                     $urandom_range(0, 3) == 0) begin
            // Equal operands, so the eq, ge and le relations hold too.
            dval = (func < sia_pkg::OP_CMP_UEQ) ? {{16{imm[15]}}, imm} : {16'h0000, imm};
        end
        add_instr(func, dval, imm, pick_word(), drain);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_cnt++;
        if (error_cnt <= MAX_PRINTS) begin
            $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
        end
    endtask

    // Sender. A transaction is offered from the head of the pending queue; after it is
    // accepted a random gap follows. Valid is written once per edge, so back-to-back
    // transactions keep it high without a glitch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_q.push_back(execute_instr(cur_entry.item));
                sent_cnt++;
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (pending_q[0].drain_first && expected_q.size() != 0) begin
                    in_valid <= 1'b0;
                end else begin
                    cur_entry = pending_q.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= cur_entry.item;
                    // Every third block of items runs with no gaps at all.
                    send_gap = ((sent_cnt / 128) % 3 == 1) ? 0 : gap_len();
                end
            end
        end
    end

    // Receiver. Each accepted result is checked against the oldest expectation, then
    // the stall for the next cycle is chosen. Once, a long hold-off lets the block
    // fill up while the sender keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", out_data.result, 32'd0);
                end else begin
                    if (out_data.result !== expected_q[0].result)
                        report_mismatch("result", out_data.result, expected_q[0].result);
                    if (out_data.dest_write !== expected_q[0].dest_write)
                        report_mismatch("dest_write", 32'(out_data.dest_write),
                                        32'(expected_q[0].dest_write));
                    if (out_data.cond_out !== expected_q[0].cond_out)
                        report_mismatch("cond_out", 32'(out_data.cond_out),
                                        32'(expected_q[0].cond_out));
                    if (out_data.cond_write !== expected_q[0].cond_write)
                        report_mismatch("cond_write", 32'(out_data.cond_write),
                                        32'(expected_q[0].cond_write));
                    void'(expected_q.pop_front());
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = ((results_seen / 100) % 3 == 2) ? 0 : gap_len();
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cond_flag = 1'b0;
        for (int i = 0; i < HWREG_COUNT; i++) hwreg_file[i] = 32'd0;

        // Directed part. The conditional move comes first, while the condition bit is
        // still clear from reset, so it must not write.
        add_instr(sia_pkg::OP_CMOVK,   32'h1234_5678, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_MOVK,    32'h0000_0000, 16'h8000, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_MOVK,    32'hFFFF_FFFF, 16'h7FFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SEQ, 32'hFFFF_8000, 16'h8000, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SNE, 32'h8000_0000, 16'h7FFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SGT, 32'h7FFF_FFFF, 16'h8000, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SGE, 32'h8000_0000, 16'h7FFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SLT, 32'h8000_0000, 16'h0000, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_SLE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_UEQ, 32'h0000_FFFF, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_UNE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_UGT, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_UGE, 32'h0000_0000, 16'h0001, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_ULT, 32'h0000_FFFE, 16'hFFFF, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_CMP_ULE, 32'h0000_0000, 16'h0000, 32'd0, 1'b0);
        // Condition bit is now set, so this conditional move writes.
        add_instr(sia_pkg::OP_CMOVK,   32'h0000_0000, 16'h8001, 32'd0, 1'b0);
        // Add overflow in both directions.
        add_instr(sia_pkg::OP_ADDK,    32'h7FFF_FFFF, 16'h0001, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_ADDK,    32'h8000_0000, 16'h8000, 32'd0, 1'b0);
        add_instr(sia_pkg::OP_MULK,    32'hFFFF_FFFF, 16'h8000, 32'd0, 1'b0);
        // Full-width field on the highest register, then read back.
        add_instr(sia_pkg::OP_SETIMM,  32'h0000_0000, hwreg_imm(5'd31, 5'd0, 6'd63),
                  32'hDEAD_BEEF, 1'b0);
        add_instr(sia_pkg::OP_GETREG,  32'h0000_0000, hwreg_imm(5'd31, 5'd0, 6'd63),
                  32'd0, 1'b0);
        // A field running past bit 31 is cut there.
        add_instr(sia_pkg::OP_SETREG,  32'hFFFF_FFFF, hwreg_imm(5'd7, 5'd28, 6'd0),
                  32'd0, 1'b0);
        add_instr(sia_pkg::OP_GETREG,  32'h0000_0000, hwreg_imm(5'd31, 5'd28, 6'd0),
                  32'd0, 1'b0);
        add_instr(sia_pkg::OP_GETREG,  32'h0000_0000, hwreg_imm(5'd0, 5'd31, 6'd5),
                  32'd0, 1'b0);
        // Unused operation codes do nothing.
        add_instr(5'd19,      32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_instr(5'd31,      32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) add_random_instr(i == 600);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_items || expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
